@@ rtl/core/led_seq_pkg.sv @@
// Shared types, constants and frame tables for the LED pattern sequencer.
// No dependencies; imported by the top level and its port checker.
package led_seq_pkg;

  localparam int unsigned COUNT_BITS = 13;  // width of the frame countdown
  localparam int unsigned DELAY_W    = 13;
  localparam int unsigned STEP_W     = 10;
  localparam int unsigned OP_W       = 3;
  localparam int unsigned SEL_W      = 3;
  localparam int unsigned LED_W      = 8;
  localparam int unsigned IDX_W      = 5;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned NUM_SEQ    = 5;
  localparam int unsigned ROM_DEPTH  = 50;
  localparam int unsigned ROM_AW     = 6;

  localparam logic [DELAY_W-1:0] MIN_DELAY_RST  = DELAY_W'(2200);
  localparam logic [DELAY_W-1:0] MAX_DELAY_RST  = DELAY_W'(5700);
  localparam logic [STEP_W-1:0]  DELAY_STEP_RST = STEP_W'(100);
  localparam logic [DELAY_W-1:0] SEQ_DELAY_RST  = DELAY_W'(4200);
  localparam logic [LED_W-1:0]   SWEEP_LEFT_END  = 8'h80;
  localparam logic [LED_W-1:0]   SWEEP_RIGHT_END = 8'h01;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_FASTER = 3'd2,
    OP_SLOWER = 3'd3,
    OP_STOP   = 3'd4
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DELAY  = 2'd0,
    CFG_MAX_DELAY  = 2'd1,
    CFG_DELAY_STEP = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [LED_W-1:0]   led_pattern;
    logic [DELAY_W-1:0] frame_delay;
    logic               running;
  } result_t;

  localparam logic [LED_W-1:0] FRAME_ROM [ROM_DEPTH] = '{
    8'h81, 8'h42, 8'h24, 8'h18, 8'h18, 8'h24, 8'h42,
    8'h08, 8'h09, 8'h09, 8'h0B, 8'h0B, 8'h09, 8'h09, 8'h08, 8'h08, 8'h09, 8'h09, 8'h0B,
    8'h0B, 8'h09, 8'h08, 8'h09, 8'h0B, 8'h0F, 8'h17, 8'h23, 8'h41, 8'h80, 8'h00,
    8'h85, 8'h86, 8'h89, 8'h89, 8'h91, 8'h91, 8'hA1, 8'h61, 8'h91, 8'h91, 8'h89, 8'h89,
    8'h3C, 8'h3A, 8'h39, 8'h3A, 8'h3C, 8'h5C, 8'h9C, 8'h5C
  };

  // Map an out-of-range sequence number onto the sweep.
  function automatic logic [SEL_W-1:0] seq_idx(input logic [SEL_W-1:0] s);
    return (s < SEL_W'(NUM_SEQ)) ? s : '0;
  endfunction

  function automatic logic [ROM_AW-1:0] seq_base(input logic [SEL_W-1:0] s);
    logic [ROM_AW-1:0] b;
    case (s)
      3'd2:    b = ROM_AW'(7);
      3'd3:    b = ROM_AW'(30);
      3'd4:    b = ROM_AW'(42);
      default: b = '0;
    endcase
    return b;
  endfunction

  function automatic logic [IDX_W:0] seq_len(input logic [SEL_W-1:0] s);
    logic [IDX_W:0] l;
    case (s)
      3'd1:    l = (IDX_W+1)'(7);
      3'd2:    l = (IDX_W+1)'(23);
      3'd3:    l = (IDX_W+1)'(12);
      3'd4:    l = (IDX_W+1)'(8);
      default: l = (IDX_W+1)'(1);
    endcase
    return l;
  endfunction

  function automatic logic [LED_W-1:0] frame_at(input logic [ROM_AW-1:0] addr);
    return (addr < ROM_AW'(ROM_DEPTH)) ? FRAME_ROM[addr] : '0;
  endfunction

endpackage

@@ rtl/core/led_pattern_sequencer_top.sv @@
// Top level of the LED pattern sequencer: command decode, countdown, sequence state.
// Depends on led_seq_pkg (constants, frame tables, result struct).
//
//   channel  | direction | handshake               | payload
//   ---------+-----------+-------------------------+----------------------------------------
//   in       | input     | in_valid_i / in_stall_o | opcode_i, sequence_select_i
//   out      | output    | out_valid_o/out_stall_i | led_pattern_o, frame_delay_o, running_o
//   cfg      | input     | cfg_we_i                | cfg_idx_i, cfg_data_i
//
// One item per clock while in_stall_o is low: each accepted transfer updates all state and
// computes its result in the same cycle, which is registered before it shows at the outputs.
// The output register plus a one-entry skid buffer decouple the sides; in_stall_o rises only
// once the skid entry is occupied, which is a registered flag.
// Reset (rst_ni low, asynchronous) restores all but the result data; both stages go empty.
// While out_stall_i is high, a shown result and a high out_valid_o hold.
module led_pattern_sequencer_top (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // command channel
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic [led_seq_pkg::OP_W-1:0]         opcode_i,
  input  logic [led_seq_pkg::SEL_W-1:0]        sequence_select_i,
  // result channel
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [led_seq_pkg::LED_W-1:0]        led_pattern_o,
  output logic [led_seq_pkg::DELAY_W-1:0]      frame_delay_o,
  output logic                                 running_o,
  // configuration writes
  input  logic                                 cfg_we_i,
  input  logic [led_seq_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [led_seq_pkg::DELAY_W-1:0]      cfg_data_i
);
  import led_seq_pkg::*;

  // configuration registers
  logic [DELAY_W-1:0] min_delay_q, max_delay_q;
  logic [STEP_W-1:0]  delay_step_q;

  // sequencer state
  logic                  active_q, active_d;
  logic [SEL_W-1:0]      cur_seq_q, cur_seq_d;
  logic [IDX_W-1:0]      frame_idx_q, frame_idx_d;
  logic [LED_W-1:0]      sweep_q, sweep_d;
  logic                  left_q, left_d;
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [DELAY_W-1:0]    delays_q [NUM_SEQ];
  logic [DELAY_W-1:0]    delay_wdata;
  logic                  delay_we;
  // mirror of delays_q[cur_sel], so the array has a single read address
  logic [DELAY_W-1:0]    cur_delay_q, cur_delay_d;

  // result stages
  logic    out_valid_q, skid_valid_q;
  result_t out_q, skid_q, res;

  logic in_xfer, out_xfer;
  logic [SEL_W-1:0] cur_sel, new_sel;

  // frame advance helpers
  logic [LED_W-1:0]  sweep_shift;
  logic [LED_W-1:0]  adv_sweep;
  logic              adv_left;
  logic [IDX_W:0]    idx_inc;
  logic [IDX_W-1:0]  adv_idx;

  // key arithmetic
  logic [DELAY_W:0]    min_plus_step, delay_sum;
  logic [COUNT_BITS:0] rem_sum;
  logic [ROM_AW-1:0]   rom_addr;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_xfer = out_valid_q && !out_stall_i;
  assign cur_sel  = seq_idx(cur_seq_q);

  // -------------------------------------------------------------- frame advance
  assign sweep_shift = left_q ? {sweep_q[LED_W-2:0], 1'b0} : {1'b0, sweep_q[LED_W-1:1]};

  always_comb begin
    adv_sweep = sweep_shift;
    adv_left  = left_q;
    if (sweep_shift == SWEEP_LEFT_END) begin
      adv_left = 1'b0;
    end
    if (sweep_shift == SWEEP_RIGHT_END) begin
      adv_left = 1'b1;
    end
    // a lost bit restarts the sweep from the left end
    if (sweep_shift == '0) begin
      adv_sweep = SWEEP_LEFT_END;
      adv_left  = 1'b0;
    end
  end

  assign idx_inc = {1'b0, frame_idx_q} + (IDX_W+1)'(1);
  assign adv_idx = (idx_inc >= seq_len(cur_sel)) ? '0 : idx_inc[IDX_W-1:0];

  assign min_plus_step = (DELAY_W+1)'(min_delay_q) + (DELAY_W+1)'(delay_step_q);
  assign delay_sum     = (DELAY_W+1)'(cur_delay_q) + (DELAY_W+1)'(delay_step_q);
  assign rem_sum       = (COUNT_BITS+1)'(rem_q) + (COUNT_BITS+1)'(delay_step_q);

  // -------------------------------------------------------------- next state
  always_comb begin
    active_d    = active_q;
    cur_seq_d   = cur_seq_q;
    frame_idx_d = frame_idx_q;
    sweep_d     = sweep_q;
    left_d      = left_q;
    rem_d       = rem_q;
    cur_delay_d = cur_delay_q;
    delay_we    = 1'b0;
    delay_wdata = cur_delay_q;

    case (op_e'(opcode_i))
      OP_START: begin
        if (sequence_select_i < SEL_W'(NUM_SEQ)) begin
          active_d    = 1'b1;
          cur_seq_d   = sequence_select_i;
          frame_idx_d = '0;
          sweep_d     = SWEEP_LEFT_END;
          left_d      = 1'b0;
          cur_delay_d = delays_q[sequence_select_i];
          rem_d       = COUNT_BITS'(delays_q[sequence_select_i]);
        end
      end
      OP_STOP: begin
        active_d = 1'b0;
      end
      OP_TICK: begin
        if (active_q) begin
          if (rem_q > COUNT_BITS'(1)) begin
            rem_d = rem_q - COUNT_BITS'(1);
          end else begin
            // advance the frame and reload the countdown
            if (cur_sel == '0) begin
              sweep_d = adv_sweep;
              left_d  = adv_left;
            end else begin
              frame_idx_d = adv_idx;
            end
            rem_d = COUNT_BITS'(cur_delay_q);
          end
        end
      end
      OP_FASTER: begin
        if (active_q) begin
          if (cur_delay_q > min_delay_q) begin
            delay_we    = 1'b1;
            delay_wdata = ((DELAY_W+1)'(cur_delay_q) >= min_plus_step)
                        ? cur_delay_q - DELAY_W'(delay_step_q) : min_delay_q;
            cur_delay_d = delay_wdata;
          end
          if (rem_q > COUNT_BITS'(min_delay_q)) begin
            rem_d = (rem_q > COUNT_BITS'(delay_step_q))
                  ? rem_q - COUNT_BITS'(delay_step_q) : COUNT_BITS'(1);
          end
        end
      end
      OP_SLOWER: begin
        if (active_q) begin
          if (cur_delay_q < max_delay_q) begin
            delay_we    = 1'b1;
            delay_wdata = (delay_sum <= (DELAY_W+1)'(max_delay_q))
                        ? delay_sum[DELAY_W-1:0] : max_delay_q;
            cur_delay_d = delay_wdata;
          end
          if (rem_q < COUNT_BITS'(max_delay_q)) begin
            // saturate at the top of the countdown range
            rem_d = rem_sum[COUNT_BITS] ? '1 : rem_sum[COUNT_BITS-1:0];
          end
        end
      end
      default: ;  // unknown command: no change
    endcase
  end

  // -------------------------------------------------------------- result of this item
  assign new_sel  = seq_idx(cur_seq_d);
  assign rom_addr = seq_base(new_sel) + ROM_AW'(frame_idx_d);

  always_comb begin
    res.running     = active_d;
    res.frame_delay = cur_delay_d;
    if (!active_d) begin
      res.led_pattern = '0;
    end else if (new_sel == '0) begin
      res.led_pattern = sweep_d;
    end else if ((IDX_W+1)'(frame_idx_d) >= seq_len(new_sel)) begin
      res.led_pattern = '0;
    end else begin
      res.led_pattern = frame_at(rom_addr);
    end
  end

  // -------------------------------------------------------------- registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_delay_q  <= MIN_DELAY_RST;
      max_delay_q  <= MAX_DELAY_RST;
      delay_step_q <= DELAY_STEP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_DELAY:  min_delay_q  <= cfg_data_i;
        CFG_MAX_DELAY:  max_delay_q  <= cfg_data_i;
        CFG_DELAY_STEP: delay_step_q <= cfg_data_i[STEP_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      cur_seq_q   <= '0;
      frame_idx_q <= '0;
      sweep_q     <= SWEEP_LEFT_END;
      left_q      <= 1'b0;
      rem_q       <= '0;
      cur_delay_q <= SEQ_DELAY_RST;
      for (int i = 0; i < NUM_SEQ; i++) begin
        delays_q[i] <= SEQ_DELAY_RST;
      end
    end else if (in_xfer) begin
      active_q    <= active_d;
      cur_seq_q   <= cur_seq_d;
      frame_idx_q <= frame_idx_d;
      sweep_q     <= sweep_d;
      left_q      <= left_d;
      rem_q       <= rem_d;
      cur_delay_q <= cur_delay_d;
      if (delay_we) begin
        delays_q[cur_sel] <= delay_wdata;
      end
    end
  end

  // Output register with one skid entry: a new result lands in the output register when
  // that is empty or draining, otherwise in the skid entry.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (!out_valid_q || out_xfer) begin
        out_valid_q  <= skid_valid_q || in_xfer;
        skid_valid_q <= 1'b0;
      end else if (in_xfer) begin
        skid_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_xfer) begin
      out_q <= skid_valid_q ? skid_q : res;
    end
    if (in_xfer && out_valid_q && !out_xfer) begin
      skid_q <= res;
    end
  end

  assign in_stall_o    = skid_valid_q;
  assign out_valid_o   = out_valid_q;
  assign led_pattern_o = out_q.led_pattern;
  assign frame_delay_o = out_q.frame_delay;
  assign running_o     = out_q.running;

endmodule

@@ rtl/core/led_seq_checker.sv @@
// Port-level checker for the LED pattern sequencer, attached by bind.
// Depends on led_seq_pkg and led_pattern_sequencer_top.
module led_seq_checker (
  input logic                                 clk_i,
  input logic                                 rst_ni,
  input logic                                 in_valid_i,
  input logic                                 in_stall_o,
  input logic [led_seq_pkg::OP_W-1:0]         opcode_i,
  input logic [led_seq_pkg::SEL_W-1:0]        sequence_select_i,
  input logic                                 out_valid_o,
  input logic                                 out_stall_i,
  input logic [led_seq_pkg::LED_W-1:0]        led_pattern_o,
  input logic [led_seq_pkg::DELAY_W-1:0]      frame_delay_o,
  input logic                                 running_o
);
  import led_seq_pkg::*;

  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(led_pattern_o)
      && $stable(frame_delay_o) && $stable(running_o))
    else $error("stalled result changed");

  // input stalls only behind a full output register
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with empty output");

  // a stopped sequencer shows dark LEDs
  a_dark_when_stopped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !running_o |-> led_pattern_o == '0)
    else $error("LEDs lit while stopped");

  // a valid start into an empty output shows a running result next cycle
  a_start_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !out_valid_o && opcode_i == OP_START && sequence_select_i < SEL_W'(NUM_SEQ)
      |=> out_valid_o && running_o)
    else $error("start did not run");

  // a stop into an empty output shows a stopped result next cycle
  a_stop_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && !out_valid_o && opcode_i == OP_STOP |=> out_valid_o && !running_o)
    else $error("stop did not halt");

endmodule

bind led_pattern_sequencer_top led_seq_checker u_led_seq_checker (.*);

@@ test/tb_led_pattern_sequencer_top.sv @@
// Testbench for led_pattern_sequencer_top: directed commands, then random command streams
// under several delay limits, checked against an in-bench model. Needs led_seq_pkg.
module tb_led_pattern_sequencer_top;
  import led_seq_pkg::*;

  localparam int unsigned IDLE_LIMIT = 5000;  // cycles without any transfer
  localparam int unsigned LONG_HOLD  = 200;
  localparam int unsigned TICKS_MAX  = (1 << COUNT_BITS) - 1;

  // frame tables of the four table sequences, laid out back to back
  localparam logic [LED_W-1:0] CHASE_FRAMES [ROM_DEPTH] = '{
    8'h81, 8'h42, 8'h24, 8'h18, 8'h18, 8'h24, 8'h42,
    8'h08, 8'h09, 8'h09, 8'h0B, 8'h0B, 8'h09, 8'h09, 8'h08, 8'h08, 8'h09, 8'h09, 8'h0B,
    8'h0B, 8'h09, 8'h08, 8'h09, 8'h0B, 8'h0F, 8'h17, 8'h23, 8'h41, 8'h80, 8'h00,
    8'h85, 8'h86, 8'h89, 8'h89, 8'h91, 8'h91, 8'hA1, 8'h61, 8'h91, 8'h91, 8'h89, 8'h89,
    8'h3C, 8'h3A, 8'h39, 8'h3A, 8'h3C, 8'h5C, 8'h9C, 8'h5C
  };
  localparam int unsigned CHASE_BASE [NUM_SEQ] = '{0, 0, 7, 30, 42};
  localparam int unsigned CHASE_LEN  [NUM_SEQ] = '{1, 7, 23, 12, 8};

  logic                 clk_i             = 1'b0;
  logic                 rst_ni            = 1'b0;
  logic                 in_valid_i        = 1'b0;
  logic                 in_stall_o;
  logic [OP_W-1:0]      opcode_i          = '0;
  logic [SEL_W-1:0]     sequence_select_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i       = 1'b0;
  logic [LED_W-1:0]     led_pattern_o;
  logic [DELAY_W-1:0]   frame_delay_o;
  logic                 running_o;
  logic                 cfg_we_i          = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i         = '0;
  logic [DELAY_W-1:0]   cfg_data_i        = '0;

  // model state
  logic                  run_q;
  logic [SEL_W-1:0]      seq_q;
  logic [IDX_W-1:0]      idx_q;
  logic [LED_W-1:0]      sweep_q;
  logic                  left_q;
  logic [COUNT_BITS-1:0] ticks_q;
  logic [DELAY_W-1:0]    delay_q [NUM_SEQ];
  logic [DELAY_W-1:0]    min_q;
  logic [DELAY_W-1:0]    max_q;
  logic [STEP_W-1:0]     step_q;

  result_t expected_frames [$];
  int unsigned mismatches    = 0;
  logic        tx_gaps_on    = 1'b0;
  logic        rx_gaps_on    = 1'b0;
  logic        long_hold_req = 1'b0;

  led_pattern_sequencer_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .opcode_i          (opcode_i),
    .sequence_select_i (sequence_select_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .led_pattern_o     (led_pattern_o),
    .frame_delay_o     (frame_delay_o),
    .running_o         (running_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Apply one accepted command to the model and queue the frame it shows.
  task automatic advance_sequencer(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel);
    int unsigned s;
    int unsigned d;
    int unsigned t;
    result_t     r;
    s = (seq_q < NUM_SEQ) ? seq_q : 0;
    d = delay_q[s];
    t = ticks_q;
    case (op)
      OP_START: begin
        if (sel < NUM_SEQ) begin
          run_q   = 1'b1;
          seq_q   = sel;
          idx_q   = '0;
          sweep_q = 8'h80;
          left_q  = 1'b0;
          ticks_q = COUNT_BITS'(delay_q[sel]);
        end
      end
      OP_STOP: begin
        run_q = 1'b0;
      end
      OP_TICK: begin
        if (run_q && t > 1) begin
          ticks_q = COUNT_BITS'(t - 1);
        end else if (run_q) begin
          // countdown ran out: show the next frame and reload
          if (s == 0) begin
            sweep_q = left_q ? {sweep_q[LED_W-2:0], 1'b0} : {1'b0, sweep_q[LED_W-1:1]};
            if (sweep_q == 8'h80) left_q = 1'b0;
            if (sweep_q == 8'h01) left_q = 1'b1;
            if (sweep_q == 8'h00) begin
              sweep_q = 8'h80;
              left_q  = 1'b0;
            end
          end else begin
            idx_q = (idx_q + 1 >= CHASE_LEN[s]) ? '0 : IDX_W'(idx_q + 1);
          end
          ticks_q = COUNT_BITS'(delay_q[s]);
        end
      end
      OP_FASTER: begin
        if (run_q) begin
          if (d > min_q) delay_q[s] = (d >= min_q + step_q) ? DELAY_W'(d - step_q) : min_q;
          if (t > min_q) ticks_q = (t > step_q) ? COUNT_BITS'(t - step_q) : COUNT_BITS'(1);
        end
      end
      OP_SLOWER: begin
        if (run_q) begin
          if (d < max_q) delay_q[s] = (d + step_q <= max_q) ? DELAY_W'(d + step_q) : max_q;
          if (t < max_q) ticks_q = (t + step_q > TICKS_MAX) ? COUNT_BITS'(TICKS_MAX)
                                                             : COUNT_BITS'(t + step_q);
        end
      end
      default: ;
    endcase
    s = (seq_q < NUM_SEQ) ? seq_q : 0;
    r.running     = run_q;
    r.frame_delay = delay_q[s];
    if (!run_q) r.led_pattern = '0;
    else if (s == 0) r.led_pattern = sweep_q;
    else if (idx_q >= CHASE_LEN[s]) r.led_pattern = '0;
    else r.led_pattern = CHASE_FRAMES[CHASE_BASE[s] + idx_q];
    expected_frames.push_back(r);
  endtask

  // Offer one command, hold it until the transfer, then update the model.
  task automatic send_command(input logic [OP_W-1:0] op, input logic [SEL_W-1:0] sel);
    int unsigned gap;
    if (tx_gaps_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 11);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i        = 1'b1;
    opcode_i          = op;
    sequence_select_i = sel;
    do @(posedge clk_i); while (in_stall_o);
    advance_sequencer(op, sel);
  endtask

  // Drop valid and wait until every queued frame has come out.
  task automatic wait_for_frames();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_frames.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [DELAY_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx)
      CFG_MIN_DELAY:  min_q  = data;
      CFG_MAX_DELAY:  max_q  = data;
      CFG_DELAY_STEP: step_q = data[STEP_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_limits(input int unsigned lo, input int unsigned hi,
                              input int unsigned step);
    write_register(CFG_MIN_DELAY, DELAY_W'(lo));
    write_register(CFG_MAX_DELAY, DELAY_W'(hi));
    write_register(CFG_DELAY_STEP, DELAY_W'(step));
  endtask

  // Mostly ticks, with keys and starts mixed in, and stops and random opcodes as noise.
  task automatic run_random(input int unsigned count);
    int unsigned      pick;
    logic [OP_W-1:0]  op;
    logic [SEL_W-1:0] sel;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      sel  = SEL_W'($urandom_range(0, 7));
      if (pick < 55) begin
        op = OP_TICK;
      end else if (pick < 65) begin
        op = OP_FASTER;
      end else if (pick < 75) begin
        op = OP_SLOWER;
      end else if (pick < 88) begin
        op = OP_START;
        if ($urandom_range(0, 5) != 0) sel = SEL_W'($urandom_range(0, NUM_SEQ - 1));
      end else if (pick < 94) begin
        op = OP_STOP;
      end else begin
        op = OP_W'($urandom_range(0, 7));
      end
      send_command(op, sel);
    end
  endtask

  // Commands that must change nothing while the sequencer is stopped.
  task automatic test_idle_commands();
    send_command(OP_TICK, 3'd0);
    send_command(OP_FASTER, 3'd1);
    send_command(OP_SLOWER, 3'd2);
    send_command(OP_STOP, 3'd3);
    send_command(3'd5, 3'd7);
    send_command(3'd6, 3'd0);
    send_command(3'd7, 3'd5);
    send_command(OP_START, 3'd5);
    send_command(OP_START, 3'd6);
    send_command(OP_START, 3'd7);
    wait_for_frames();
  endtask

  task automatic test_start_and_keys();
    for (int i = 0; i < NUM_SEQ; i++) send_command(OP_START, SEL_W'(i));
    send_command(OP_FASTER, 3'd0);
    send_command(OP_SLOWER, 3'd0);
    send_command(OP_TICK, 3'd7);
    send_command(OP_START, 3'd2);  // restart while running
    send_command(OP_STOP, 3'd0);
    wait_for_frames();
  endtask

  // Push the countdown past its top so it saturates.
  task automatic test_count_saturation();
    apply_limits(1, TICKS_MAX, (1 << STEP_W) - 1);
    send_command(OP_START, 3'd1);
    repeat (4) send_command(OP_SLOWER, 3'd0);
    send_command(OP_FASTER, 3'd0);
    wait_for_frames();
  endtask

  task automatic test_wide_limits();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
    run_random(150);
    wait_for_frames();
    apply_limits(1, 6, (1 << STEP_W) - 1);
    run_random(200);
    wait_for_frames();
  endtask

  // Short delays keep frames moving; fill the block under a long output hold.
  task automatic test_short_delays();
    apply_limits(2, 12, 3);
    run_random(100);
    long_hold_req = 1'b1;
    run_random(100);
    wait_for_frames();
    run_random(100);
    wait_for_frames();
  endtask

  task automatic test_zero_delay();
    apply_limits(0, 4, 1);
    run_random(200);
    wait_for_frames();
  endtask

  task automatic test_crossed_limits();
    apply_limits(9, 3, 2);
    run_random(150);
    wait_for_frames();
    apply_limits(TICKS_MAX, TICKS_MAX, 1);
    run_random(100);
    wait_for_frames();
  endtask

  task automatic test_steady_flow();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    apply_limits(3, 10, 1);
    run_random(300);
    wait_for_frames();
    apply_limits(MIN_DELAY_RST, MAX_DELAY_RST, DELAY_STEP_RST);
    run_random(150);
    wait_for_frames();
  endtask

  // Output stall: random bursts, plus one long hold on request.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i = 1'b1;
      end else if (rx_gaps_on && $urandom_range(0, 5) == 0) begin
        hold_left   = $urandom_range(1, 11) - 1;
        out_stall_i = 1'b1;
      end else begin
        out_stall_i = 1'b0;
      end
    end
  end

  // Compare every result transfer with the oldest expected frame.
  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_frames.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: led %h delay %0d running %0b",
                   led_pattern_o, frame_delay_o, running_o);
      end else begin
        want = expected_frames.pop_front();
        if (led_pattern_o !== want.led_pattern || frame_delay_o !== want.frame_delay ||
            running_o !== want.running) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected led %h delay %0d running %0b, ",
                      "got led %h delay %0d running %0b"},
                     want.led_pattern, want.frame_delay, want.running,
                     led_pattern_o, frame_delay_o, running_o);
        end
      end
    end
  end

  // End the run if no transfer happens on either side for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    run_q   = 1'b0;
    seq_q   = '0;
    idx_q   = '0;
    sweep_q = 8'h80;
    left_q  = 1'b0;
    ticks_q = '0;
    for (int i = 0; i < NUM_SEQ; i++) delay_q[i] = SEQ_DELAY_RST;
    min_q  = MIN_DELAY_RST;
    max_q  = MAX_DELAY_RST;
    step_q = DELAY_STEP_RST;

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_commands();
    test_start_and_keys();
    test_count_saturation();
    test_wide_limits();
    test_short_delays();
    test_zero_delay();
    test_crossed_limits();
    test_steady_flow();

    if (mismatches == 0 && expected_frames.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
